>>> rtl/graph_bridge_finder_macros.svh
// assertion macros used by the bridge finder checker
`ifndef GRAPH_BRIDGE_FINDER_MACROS_SVH
`define GRAPH_BRIDGE_FINDER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define GBF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GBF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/gbf_pkg.sv
// shared types and constants for the bridge finder
package gbf_pkg;

    localparam int MAX_NODES   = 32;
    localparam int MAX_EDGES   = 64;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int NCNT_W      = NODE_W + 1;
    localparam int EDGE_AW     = $clog2(MAX_EDGES);
    localparam int ECNT_W      = EDGE_AW + 1;
    localparam int MAX_BRIDGES = 31;
    localparam int BCNT_W      = 5;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] par;
        logic              hp;
        logic [ECNT_W-1:0] cursor;
        logic [NODE_W-1:0] disc;
        logic [NODE_W-1:0] low;
    } frame_t;

    typedef struct packed {
        logic add_edge;
        logic run_start;
        logic chk_eval;
        logic root_start;
        logic root_next;
        logic root_visit;
        logic edge_read;
        logic push;
        logic back_eval;
        logic pop_eval;
        logic emit_done;
    } cmd_t;

    typedef struct packed {
        logic chk_end;
        logic root_end;
        logic root_visited;
        logic cursor_end;
        logic nb_skip;
        logic nb_visited;
        logic has_parent;
        logic bridge_hit;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/gbf_dp.sv
// datapath: edge store, discovery times, walk stack, dfs registers, result register
module gbf_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [gbf_pkg::NCNT_W-1:0]   cfg_wdata,
    input  logic [gbf_pkg::NODE_W-1:0]   end_a,
    input  logic [gbf_pkg::NODE_W-1:0]   end_b,
    input  gbf_pkg::cmd_t                cmd,
    output gbf_pkg::sts_t                sts,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         is_done,
    output logic [gbf_pkg::NODE_W-1:0]   bridge_parent,
    output logic [gbf_pkg::NODE_W-1:0]   bridge_child,
    output logic                         dropped_edges,
    output logic                         last
);

    logic [gbf_pkg::NCNT_W-1:0]   nc_reg;
    logic [gbf_pkg::NCNT_W-1:0]   nuse;
    logic [gbf_pkg::ECNT_W-1:0]   total_reg;
    logic                         ovf_reg;
    logic [gbf_pkg::ECNT_W-1:0]   scan_reg;
    logic [gbf_pkg::NCNT_W-1:0]   root_reg;
    logic [gbf_pkg::MAX_NODES-1:0] vis_reg;
    gbf_pkg::frame_t              cur_reg;
    logic [gbf_pkg::NCNT_W-1:0]   time_reg;
    logic [gbf_pkg::NCNT_W-1:0]   sp_reg;
    logic [gbf_pkg::BCNT_W-1:0]   bcnt_reg;

    logic [2*gbf_pkg::NODE_W-1:0] edge_mem [gbf_pkg::MAX_EDGES];
    logic [2*gbf_pkg::NODE_W-1:0] edge_q;
    logic [gbf_pkg::NODE_W-1:0]   disc_mem [gbf_pkg::MAX_NODES];
    logic [gbf_pkg::NODE_W-1:0]   disc_q;
    gbf_pkg::frame_t              stk_mem [gbf_pkg::MAX_NODES];
    gbf_pkg::frame_t              stk_q;

    logic                         add_ok;
    logic [gbf_pkg::EDGE_AW-1:0]  rd_addr;
    logic [gbf_pkg::NODE_W-1:0]   ea;
    logic [gbf_pkg::NODE_W-1:0]   eb;
    logic                         edge_bad;
    logic [gbf_pkg::NODE_W-1:0]   nb;
    logic                         nb_match;
    logic [gbf_pkg::NODE_W-1:0]   vis_node;
    logic                         visit;
    logic [gbf_pkg::NCNT_W-1:0]   sp_m1;
    logic                         hit;
    logic                         out_free;

    logic                         out_valid_reg;
    logic                         is_done_reg;
    logic [gbf_pkg::NODE_W-1:0]   par_reg;
    logic [gbf_pkg::NODE_W-1:0]   chd_reg;
    logic                         drop_reg;

    always_comb
    begin
        nuse = (nc_reg > gbf_pkg::NCNT_W'(gbf_pkg::MAX_NODES))
             ? gbf_pkg::NCNT_W'(gbf_pkg::MAX_NODES) : nc_reg;
        add_ok = ({1'b0, end_a} < nuse) && ({1'b0, end_b} < nuse)
              && (total_reg < gbf_pkg::ECNT_W'(gbf_pkg::MAX_EDGES));
        rd_addr = cmd.edge_read ? cur_reg.cursor[gbf_pkg::EDGE_AW-1:0]
                                : scan_reg[gbf_pkg::EDGE_AW-1:0];
        ea = edge_q[2*gbf_pkg::NODE_W-1:gbf_pkg::NODE_W];
        eb = edge_q[gbf_pkg::NODE_W-1:0];
        edge_bad = ({1'b0, ea} >= nuse) || ({1'b0, eb} >= nuse);
        nb_match = 1'b1;
        if (ea == cur_reg.node)
        begin
            nb = eb;
        end
        else
        begin
            nb = ea;
            nb_match = (eb == cur_reg.node);
        end
        visit = cmd.root_visit || cmd.push;
        vis_node = cmd.root_visit ? root_reg[gbf_pkg::NODE_W-1:0] : nb;
        sp_m1 = sp_reg - 1'b1;
        hit = (cur_reg.low > stk_q.disc)
           && (bcnt_reg < gbf_pkg::BCNT_W'(gbf_pkg::MAX_BRIDGES));
        out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        sts.chk_end      = (scan_reg == total_reg);
        sts.root_end     = (root_reg == nuse);
        sts.root_visited = vis_reg[root_reg[gbf_pkg::NODE_W-1:0]];
        sts.cursor_end   = (cur_reg.cursor == total_reg);
        sts.nb_skip      = edge_bad || !nb_match || (cur_reg.hp && (nb == cur_reg.par));
        sts.nb_visited   = vis_reg[nb];
        sts.has_parent   = cur_reg.hp;
        sts.bridge_hit   = hit;
        sts.out_free     = out_free;
    end

    // memories, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.add_edge && add_ok)
        begin
            edge_mem[total_reg[gbf_pkg::EDGE_AW-1:0]] <= {end_a, end_b};
        end
        edge_q <= edge_mem[rd_addr];
        if (visit)
        begin
            disc_mem[vis_node] <= time_reg[gbf_pkg::NODE_W-1:0];
        end
        disc_q <= disc_mem[nb];
        if (cmd.push)
        begin
            stk_mem[sp_reg[gbf_pkg::NODE_W-1:0]] <= cur_reg;
        end
        stk_q <= stk_mem[sp_m1[gbf_pkg::NODE_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg        <= gbf_pkg::NCNT_W'(gbf_pkg::MAX_NODES);
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            scan_reg      <= '0;
            root_reg      <= '0;
            vis_reg       <= '0;
            cur_reg       <= '0;
            time_reg      <= '0;
            sp_reg        <= '0;
            bcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            is_done_reg   <= 1'b0;
            par_reg       <= '0;
            chd_reg       <= '0;
            drop_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                nc_reg <= cfg_wdata;
            end
            if (cmd.add_edge)
            begin
                if (add_ok)
                begin
                    total_reg <= total_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.run_start)
            begin
                scan_reg <= '0;
            end
            // stored edge made stale by a lower node count
            if (cmd.chk_eval)
            begin
                scan_reg <= scan_reg + 1'b1;
                if (edge_bad)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.root_start)
            begin
                root_reg <= '0;
                vis_reg  <= '0;
                time_reg <= '0;
                sp_reg   <= '0;
                bcnt_reg <= '0;
            end
            if (cmd.root_next)
            begin
                root_reg <= root_reg + 1'b1;
            end
            if (visit)
            begin
                vis_reg[vis_node] <= 1'b1;
                time_reg          <= time_reg + 1'b1;
            end
            if (cmd.root_visit)
            begin
                cur_reg.node   <= root_reg[gbf_pkg::NODE_W-1:0];
                cur_reg.par    <= '0;
                cur_reg.hp     <= 1'b0;
                cur_reg.cursor <= '0;
                cur_reg.disc   <= time_reg[gbf_pkg::NODE_W-1:0];
                cur_reg.low    <= time_reg[gbf_pkg::NODE_W-1:0];
            end
            if (cmd.edge_read)
            begin
                cur_reg.cursor <= cur_reg.cursor + 1'b1;
            end
            if (cmd.push)
            begin
                sp_reg         <= sp_reg + 1'b1;
                cur_reg.node   <= nb;
                cur_reg.par    <= cur_reg.node;
                cur_reg.hp     <= 1'b1;
                cur_reg.cursor <= '0;
                cur_reg.disc   <= time_reg[gbf_pkg::NODE_W-1:0];
                cur_reg.low    <= time_reg[gbf_pkg::NODE_W-1:0];
            end
            if (cmd.back_eval && (disc_q < cur_reg.low))
            begin
                cur_reg.low <= disc_q;
            end
            // child frame done: fold its low link into the parent
            if (cmd.pop_eval)
            begin
                sp_reg  <= sp_m1;
                cur_reg <= stk_q;
                if (cur_reg.low < stk_q.low)
                begin
                    cur_reg.low <= cur_reg.low;
                end
                if (hit)
                begin
                    bcnt_reg <= bcnt_reg + 1'b1;
                end
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.pop_eval && hit)
            begin
                out_valid_reg <= 1'b1;
                is_done_reg   <= 1'b0;
                par_reg       <= stk_q.node;
                chd_reg       <= cur_reg.node;
                drop_reg      <= 1'b0;
            end
            if (cmd.emit_done)
            begin
                out_valid_reg <= 1'b1;
                is_done_reg   <= 1'b1;
                par_reg       <= '0;
                chd_reg       <= '0;
                drop_reg      <= ovf_reg;
                total_reg     <= '0;
                ovf_reg       <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_done       = is_done_reg;
    assign bridge_parent = par_reg;
    assign bridge_child  = chd_reg;
    assign dropped_edges = drop_reg;
    assign last          = is_done_reg;

endmodule

>>> rtl/gbf_ctrl.sv
// controller: sequences edge loading, the range check and the depth-first walk
module gbf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          func,
    output logic          in_ready,
    input  gbf_pkg::sts_t sts,
    output gbf_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_RD,
        S_CHK_CK,
        S_ROOT,
        S_EDGE_RD,
        S_EDGE_CK,
        S_BACK,
        S_POP,
        S_POP_CK,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (func)
                    begin
                        cmd.run_start = 1'b1;
                        state_next    = S_CHK_RD;
                    end
                    else
                    begin
                        cmd.add_edge = 1'b1;
                    end
                end
            end
            S_CHK_RD:
            begin
                if (sts.chk_end)
                begin
                    cmd.root_start = 1'b1;
                    state_next     = S_ROOT;
                end
                else
                begin
                    state_next = S_CHK_CK;
                end
            end
            S_CHK_CK:
            begin
                cmd.chk_eval = 1'b1;
                state_next   = S_CHK_RD;
            end
            S_ROOT:
            begin
                if (sts.root_end)
                begin
                    state_next = S_DONE;
                end
                else if (sts.root_visited)
                begin
                    cmd.root_next = 1'b1;
                end
                else
                begin
                    cmd.root_visit = 1'b1;
                    state_next     = S_EDGE_RD;
                end
            end
            S_EDGE_RD:
            begin
                if (sts.cursor_end)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cmd.edge_read = 1'b1;
                    state_next    = S_EDGE_CK;
                end
            end
            S_EDGE_CK:
            begin
                if (sts.nb_skip)
                begin
                    state_next = S_EDGE_RD;
                end
                else if (sts.nb_visited)
                begin
                    state_next = S_BACK;
                end
                else
                begin
                    cmd.push   = 1'b1;
                    state_next = S_EDGE_RD;
                end
            end
            S_BACK:
            begin
                cmd.back_eval = 1'b1;
                state_next    = S_EDGE_RD;
            end
            S_POP:
            begin
                if (sts.has_parent)
                begin
                    state_next = S_POP_CK;
                end
                else
                begin
                    cmd.root_next = 1'b1;
                    state_next    = S_ROOT;
                end
            end
            S_POP_CK:
            begin
                // hold while a bridge request cannot enter the result register
                if (!sts.bridge_hit || sts.out_free)
                begin
                    cmd.pop_eval = 1'b1;
                    state_next   = S_EDGE_RD;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

>>> rtl/graph_bridge_finder.sv
// bridge finder: an add-edge request stores one edge or marks it dropped; a run first checks
// the E stored edges against the node count, then walks the graph, reading the edge store
// through its one read port once per edge per visited node; input is held off until the done
// request enters the result register
// async active-low reset clears control state and sets node_count to 32; the edge store,
// discovery times and walk stack have no reset; clearing the edge count empties the edge store
module graph_bridge_finder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [gbf_pkg::NCNT_W-1:0] cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       func,
    input  logic [gbf_pkg::NODE_W-1:0] end_a,
    input  logic [gbf_pkg::NODE_W-1:0] end_b,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       is_done,
    output logic [gbf_pkg::NODE_W-1:0] bridge_parent,
    output logic [gbf_pkg::NODE_W-1:0] bridge_child,
    output logic                       dropped_edges,
    output logic                       last
);

    gbf_pkg::cmd_t cmd;
    gbf_pkg::sts_t sts;

    gbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gbf_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .end_a         (end_a),
        .end_b         (end_b),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .is_done       (is_done),
        .bridge_parent (bridge_parent),
        .bridge_child  (bridge_child),
        .dropped_edges (dropped_edges),
        .last          (last)
    );

endmodule

>>> rtl/gbf_checker.sv
// port-level checks for the bridge finder and their binding
`include "graph_bridge_finder_macros.svh"

module gbf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       is_done,
    input logic [gbf_pkg::NODE_W-1:0] bridge_parent,
    input logic [gbf_pkg::NODE_W-1:0] bridge_child,
    input logic                       dropped_edges,
    input logic                       last
);

    `GBF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `GBF_ASSERT_IMP(a_last_done, out_valid, last == is_done, "last differs from done marker")
    `GBF_ASSERT_IMP(a_bridge_nodrop, out_valid && !is_done, !dropped_edges, "drop flag on bridge")
    `GBF_ASSERT_IMP(a_done_zero, out_valid && is_done, (bridge_parent == '0) && (bridge_child == '0), "done request carries endpoints")
    `GBF_ASSERT_IMP(a_busy_no_in, out_valid && !is_done, !in_ready, "input taken during a run")

endmodule

bind graph_bridge_finder gbf_checker u_gbf_checker (.*);
